### hdl/lcsre_pkg.sv
// Shared types and constants for the LCS length row engine.
// Depends on nothing; the cell and the top level use it by scoped names.
package lcsre_pkg;

	localparam int MAX_N_DEF       = 64;
	localparam int TOKEN_WIDTH_DEF = 32;

	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 7;
	localparam int TOKEN_IN_W = 32;
	localparam int VALUE_W    = 7;
	localparam int LEN_W      = 7;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_B_LENGTH = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_PROC  = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef struct packed {
		logic clr;
		logic ld;
		logic in_use;
	} cell_ctrl_t;

endpackage

### hdl/lcsre_cell.sv
// One column cell of the LCS row chain: holds one B token and one row entry.
// Depends on lcsre_pkg for the control struct.
module lcsre_cell #(
	parameter int MAX_N = lcsre_pkg::MAX_N_DEF,
	parameter int TW    = lcsre_pkg::TOKEN_WIDTH_DEF,
	parameter int VW    = $clog2(MAX_N + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcsre_pkg::cell_ctrl_t ctrl,
	input  logic [TW-1:0]         ld_token,
	input  logic                  act_in,
	input  logic [TW-1:0]         tok_in,
	input  logic [VW-1:0]         left_new,
	input  logic [VW-1:0]         left_old,
	output logic                  act_out,
	output logic [TW-1:0]         tok_out,
	output logic [VW-1:0]         row_val,
	output logic [VW-1:0]         old_val
);

	logic          act_q;
	logic [TW-1:0] tok_q;
	logic [TW-1:0] b_q;
	logic [VW-1:0] row_q;
	logic [VW-1:0] old_q;
	logic [VW:0]   inc;
	logic [VW-1:0] upd;

	always_comb begin
		inc = (VW+1)'(left_old) + (VW+1)'(1);
		if (tok_in == b_q) begin
			upd = (inc > (VW+1)'(MAX_N)) ? VW'(MAX_N) : inc[VW-1:0];
		end else begin
			upd = (left_new > row_q) ? left_new : row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			row_q <= '0;
		end else begin
			act_q <= act_in;
			if (ctrl.clr) begin
				row_q <= '0;
			end else if (act_in && ctrl.in_use) begin
				row_q <= upd;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_in;
		if (act_in) begin
			old_q <= row_q;
		end
		if (ctrl.ld) begin
			b_q <= ld_token;
		end
	end

	assign act_out = act_q;
	assign tok_out = tok_q;
	assign row_val = row_q;
	assign old_val = old_q;

endmodule

### hdl/lcs_length_row_engine_unit.sv
// Top level of the LCS length row engine: request and response channels,
// the b_length register on an APB-style port, and the chain of column cells.
// Depends on lcsre_pkg and lcsre_cell.
//
// The engine keeps one row of the longest-common-subsequence table against a
// stored sequence B of up to MAX_N tokens, one token and one row entry in each
// of MAX_N column cells. The response to a clear, load or read request is
// registered in the cycle after its acceptance. A process request sends the A
// token down the cell chain one cell per cycle, and its response is registered
// once the token leaves the last cell; no new request is taken until that
// response is in the output register. Every response carries row[n], with n the
// B length in use, except a read, which carries the column it names, or zero
// for an index beyond MAX_N. A new request is taken while a response still
// waits, as long as the response is taken in the same cycle.
module lcs_length_row_engine_unit #(
	parameter int MAX_N       = lcsre_pkg::MAX_N_DEF,
	parameter int TOKEN_WIDTH = lcsre_pkg::TOKEN_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lcsre_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lcsre_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lcsre_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [lcsre_pkg::FUNC_W-1:0]     func,
	input  logic [lcsre_pkg::IDX_W-1:0]      index,
	input  logic [lcsre_pkg::TOKEN_IN_W-1:0] token,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [lcsre_pkg::VALUE_W-1:0]    value
);

	localparam int VW = $clog2(MAX_N + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                            state_q;
	state_t                            state_d;
	logic [lcsre_pkg::LEN_W-1:0]       b_length_q;
	logic [lcsre_pkg::LEN_W-1:0]       n_len;
	logic                              rsp_valid_q;
	logic [lcsre_pkg::VALUE_W-1:0]     value_q;
	logic                              accept;
	logic                              cfg_wr;
	lcsre_pkg::func_t                  func_c;
	logic                              done;
	logic [VW-1:0]                     row_n;
	logic [VW-1:0]                     row_rd;

	logic                              act_c [0:MAX_N];
	logic [TOKEN_WIDTH-1:0]            tok_c [0:MAX_N];
	logic [VW-1:0]                     rows  [0:MAX_N];
	logic [VW-1:0]                     olds  [0:MAX_N];
	lcsre_pkg::cell_ctrl_t             ctrl_c [1:MAX_N];
	logic [MAX_N:1]                    act_vec;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_length_q <= '0;
		end else if (cfg_wr && (paddr[2] == lcsre_pkg::REG_B_LENGTH)) begin
			b_length_q <= pwdata[lcsre_pkg::LEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == lcsre_pkg::REG_B_LENGTH) ?
		lcsre_pkg::APB_DATA_W'(b_length_q) : '0;

	assign n_len = (int'(b_length_q) > MAX_N) ? lcsre_pkg::LEN_W'(MAX_N) : b_length_q;

	assign func_c    = lcsre_pkg::func_t'(func);
	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign done      = act_c[MAX_N];

	assign act_c[0] = accept && (func_c == lcsre_pkg::FUNC_PROC);
	assign tok_c[0] = TOKEN_WIDTH'(token);
	assign rows[0]  = '0;
	assign olds[0]  = '0;

	for (genvar j = 1; j <= MAX_N; j++) begin : g_cell
		assign ctrl_c[j].clr    = accept && (func_c == lcsre_pkg::FUNC_CLEAR);
		assign ctrl_c[j].ld     = accept && (func_c == lcsre_pkg::FUNC_LOAD) &&
			(int'(index) == j - 1);
		assign ctrl_c[j].in_use = (int'(n_len) >= j);
		assign act_vec[j]       = act_c[j];

		lcsre_cell #(
			.MAX_N (MAX_N),
			.TW    (TOKEN_WIDTH),
			.VW    (VW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl_c[j]),
			.ld_token (TOKEN_WIDTH'(token)),
			.act_in   (act_c[j-1]),
			.tok_in   (tok_c[j-1]),
			.left_new (rows[j-1]),
			.left_old (olds[j-1]),
			.act_out  (act_c[j]),
			.tok_out  (tok_c[j]),
			.row_val  (rows[j]),
			.old_val  (olds[j])
		);
	end

	assign row_n  = rows[VW'(n_len)];
	assign row_rd = (int'(index) <= MAX_N) ? rows[VW'(index)] : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (func_c == lcsre_pkg::FUNC_PROC)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((accept && (func_c != lcsre_pkg::FUNC_PROC)) ||
			    ((state_q == ST_RUN) && done)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && done) begin
			value_q <= lcsre_pkg::VALUE_W'(row_n);
		end else if (accept) begin
			case (func_c)
				lcsre_pkg::FUNC_CLEAR: value_q <= '0;
				lcsre_pkg::FUNC_LOAD:  value_q <= lcsre_pkg::VALUE_W'(row_n);
				lcsre_pkg::FUNC_READ:  value_q <= lcsre_pkg::VALUE_W'(row_rd);
				default:               value_q <= value_q;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;

	a_one_token_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_vec))
		else $error("more than one A token in the cell chain");

	a_run_no_pending_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !rsp_valid_q)
		else $error("response pending while a token runs down the chain");

	a_done_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_RUN))
		else $error("chain completion outside a process request");

	a_clear_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func_c == lcsre_pkg::FUNC_CLEAR)) |=> (rsp_valid_q && (value_q == '0)))
		else $error("clear request did not answer zero");

endmodule

### tb/tb.sv
// Self-checking testbench for lcs_length_row_engine_unit. It drives requests, writes the
// b_length register over APB, and checks each response against a bench copy of the LCS row.
// Depends on lcsre_pkg and the top level of the engine; reads no files.
module tb;
	import lcsre_pkg::*;

	localparam int ROW_MAX = MAX_N_DEF;
	localparam int IDX_MAX = (1 << IDX_W) - 1;
	localparam int ITEM_TARGET = 1350;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = ROW_MAX + 16;
	localparam logic [APB_ADDR_W-1:0] B_LENGTH_ADDR = {REG_B_LENGTH, 2'b00};

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [FUNC_W-1:0] func = FUNC_CLEAR;
	logic [IDX_W-1:0] index = '0;
	logic [TOKEN_IN_W-1:0] token = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [VALUE_W-1:0] value;

	logic [TOKEN_IN_W-1:0] b_seq [ROW_MAX];
	logic [ROW_MAX-1:0] b_loaded = '0;
	int unsigned dp_row [ROW_MAX+1];
	logic [LEN_W-1:0] b_len_reg = '0;
	logic [VALUE_W-1:0] pending_values [$];
	logic [VALUE_W-1:0] expected_head;
	logic [TOKEN_IN_W-1:0] alphabet [$];
	int mismatch_cnt = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit sender_bursty = 1'b0;
	bit hold_wanted = 1'b0;
	rx_mode_t recv_mode = RX_ALWAYS;

	lcs_length_row_engine_unit u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("lcs_length_row_engine_unit verification failed");
		$finish;
	end

	function automatic int unsigned used_len();
		return (b_len_reg > ROW_MAX) ? ROW_MAX : b_len_reg;
	endfunction

	function automatic bit prefix_loaded(int unsigned n);
		for (int j = 0; j < n; j++)
			if (!b_loaded[j]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [TOKEN_IN_W-1:0] pick_token();
		if ($urandom_range(0, 9) == 0 || alphabet.size() == 0) return $urandom;
		return alphabet[$urandom_range(0, alphabet.size() - 1)];
	endfunction

	function automatic logic [VALUE_W-1:0] lcs_step_value(func_t f, logic [IDX_W-1:0] idx,
			logic [TOKEN_IN_W-1:0] tok);
		int unsigned prev_row [ROW_MAX+1];
		int unsigned n;
		n = used_len();
		case (f)
		FUNC_CLEAR: begin
			foreach (dp_row[j]) dp_row[j] = 0;
		end
		FUNC_LOAD: begin
			if (idx < ROW_MAX) begin
				b_seq[idx] = tok;
				b_loaded[idx] = 1'b1;
			end
		end
		FUNC_PROC: begin
			prev_row = dp_row;
			dp_row[0] = 0;
			for (int j = 1; j <= n; j++) begin
				if (tok == b_seq[j-1]) begin
					dp_row[j] = (prev_row[j-1] + 1 > ROW_MAX) ? ROW_MAX : prev_row[j-1] + 1;
				end else begin
					dp_row[j] = (dp_row[j-1] > prev_row[j]) ? dp_row[j-1] : prev_row[j];
				end
			end
		end
		default: begin
			return (idx <= ROW_MAX) ? VALUE_W'(dp_row[idx]) : '0;
		end
		endcase
		return VALUE_W'(dp_row[n]);
	endfunction

	task automatic report_mismatch(input string what, input logic [APB_DATA_W-1:0] want,
			input logic [APB_DATA_W-1:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_values.size() == 0) begin
				report_mismatch("response with no request outstanding", '0,
					APB_DATA_W'(value));
			end else begin
				expected_head = pending_values.pop_front();
				if (value !== expected_head)
					report_mismatch("value", APB_DATA_W'(expected_head), APB_DATA_W'(value));
			end
		end
	end

	initial begin
		int hold_left;
		int pat;
		hold_left = 0;
		pat = 0;
		forever begin
			@(negedge clk);
			pat++;
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready = 1'b0;
			end else begin
				case (recv_mode)
				RX_ALWAYS: rsp_ready = 1'b1;
				RX_RANDOM: rsp_ready = ($urandom_range(0, 3) != 0);
				default: rsp_ready = ((pat % 7) < 4);
				endcase
			end
		end
	end

	task automatic send_item(input func_t f, input logic [IDX_W-1:0] idx,
			input logic [TOKEN_IN_W-1:0] tok);
		@(negedge clk);
		req_valid = 1'b1;
		func = f;
		index = idx;
		token = tok;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_values.insert(pending_values.size(), lcs_step_value(f, idx, tok));
		items_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (sender_bursty) begin
				@(negedge clk);
				req_valid = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
	endtask

	task automatic wait_responses_done();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_values.size() != 0) @(posedge clk);
	endtask

	task automatic write_b_length(input logic [LEN_W-1:0] len);
		wait_responses_done();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = B_LENGTH_ADDR;
		pwdata = APB_DATA_W'(len);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		b_len_reg = len;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== APB_DATA_W'(len))
			report_mismatch("b_length readback", APB_DATA_W'(len), prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic test_reset_state();
		send_item(FUNC_READ, '0, '0);
		send_item(FUNC_READ, IDX_W'(IDX_MAX), '1);
		send_item(FUNC_READ, IDX_W'(ROW_MAX), '0);
		send_item(FUNC_PROC, '0, TOKEN_IN_W'($urandom));
		send_item(FUNC_CLEAR, '0, '0);
	endtask

	task automatic test_directed_cases();
		write_b_length(3);
		send_item(FUNC_LOAD, 0, '0);
		send_item(FUNC_LOAD, 1, '1);
		send_item(FUNC_LOAD, 2, 32'h1234_5678);
		send_item(FUNC_LOAD, IDX_W'(ROW_MAX), 32'hA5A5_A5A5);
		send_item(FUNC_LOAD, IDX_W'(IDX_MAX), '1);
		send_item(FUNC_PROC, 0, '1);
		send_item(FUNC_PROC, IDX_W'(IDX_MAX), '0);
		send_item(FUNC_PROC, 0, 32'h1234_5678);
		for (int j = 0; j <= 3; j++) send_item(FUNC_READ, IDX_W'(j), '0);
		send_item(FUNC_READ, IDX_W'(ROW_MAX), '1);
		send_item(FUNC_READ, IDX_W'(ROW_MAX + 1), '0);
		write_b_length(1);
		send_item(FUNC_PROC, 0, '0);
		send_item(FUNC_READ, 3, '0);
		write_b_length(LEN_W'(IDX_MAX));
		send_item(FUNC_READ, IDX_W'(ROW_MAX), '0);
		send_item(FUNC_CLEAR, IDX_W'(IDX_MAX), '1);
		write_b_length(3);
		send_item(FUNC_READ, 3, '0);
	endtask

	task automatic test_backpressure();
		write_b_length(8);
		alphabet.delete();
		repeat (2) alphabet.insert(alphabet.size(), $urandom);
		send_item(FUNC_CLEAR, '0, '0);
		for (int j = 0; j < 8; j++) send_item(FUNC_LOAD, IDX_W'(j), pick_token());
		sender_bursty = 1'b0;
		recv_mode = RX_ALWAYS;
		hold_wanted = 1'b1;
		repeat (20) begin
			send_item(FUNC_PROC, IDX_W'($urandom), pick_token());
			send_item(FUNC_READ, IDX_W'($urandom_range(0, 8)), '0);
		end
	endtask

	task automatic send_lcs_sequence();
		int unsigned n;
		n = used_len();
		if (!prefix_loaded(n) || $urandom_range(0, 9) < 7) begin
			send_item(FUNC_CLEAR, IDX_W'($urandom), $urandom);
			for (int j = 0; j < n; j++) send_item(FUNC_LOAD, IDX_W'(j), pick_token());
		end
		repeat ($urandom_range(1, 16)) send_item(FUNC_PROC, IDX_W'($urandom), pick_token());
		repeat ($urandom_range(1, 4)) send_item(FUNC_READ, IDX_W'($urandom_range(0, n)), $urandom);
	endtask

	task automatic send_noise_item();
		func_t f;
		logic [IDX_W-1:0] idx;
		int unsigned n;
		n = used_len();
		f = func_t'($urandom_range(0, 3));
		if ($urandom_range(0, 4) != 0) idx = IDX_W'($urandom_range(0, ROW_MAX));
		else idx = IDX_W'($urandom_range(ROW_MAX + 1, IDX_MAX));
		if (f == FUNC_PROC && !prefix_loaded(n)) begin
			f = FUNC_LOAD;
			for (int j = n - 1; j >= 0; j--)
				if (!b_loaded[j]) idx = IDX_W'(j);
		end
		send_item(f, idx, ($urandom_range(0, 1) != 0) ? pick_token() : $urandom);
	endtask

	task automatic test_random_sequences();
		logic [LEN_W-1:0] corner_lens [4];
		logic [LEN_W-1:0] len;
		int phase;
		int phase_end;
		int r;
		corner_lens = '{LEN_W'(0), LEN_W'(ROW_MAX), LEN_W'(IDX_MAX), LEN_W'(1)};
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 19);
			if (phase < 4) len = corner_lens[phase];
			else if (r < 14) len = LEN_W'($urandom_range(1, 12));
			else if (r < 17) len = LEN_W'($urandom_range(13, ROW_MAX - 1));
			else len = LEN_W'($urandom_range(ROW_MAX, IDX_MAX));
			write_b_length(len);
			alphabet.delete();
			repeat ($urandom_range(1, 6)) alphabet.insert(alphabet.size(), $urandom);
			recv_mode = rx_mode_t'($urandom_range(0, 2));
			sender_bursty = ($urandom_range(0, 3) != 0);
			phase_end = items_sent + $urandom_range(60, 140);
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) < 7) send_lcs_sequence();
				else send_noise_item();
			end
			phase++;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_directed_cases();
		test_backpressure();
		test_random_sequences();
		wait_responses_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_values.size() == 0) begin
			$display("lcs_length_row_engine_unit verification clean");
		end else begin
			$display("lcs_length_row_engine_unit verification failed");
		end
		$finish;
	end

endmodule

### files.f
hdl/lcsre_pkg.sv
hdl/lcsre_cell.sv
hdl/lcs_length_row_engine_unit.sv
tb/tb.sv
